// File: sv/clce_pkg.sv
// ----------------------------------------------------------------------------
// clce_pkg
// Shared types and constants for the circular list cursor engine.
// ----------------------------------------------------------------------------
package clce_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned RND_W        = 31;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CNT_OUT_W    = 5;
  localparam int unsigned RND_CNT_W    = $clog2(RND_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_NEXT    = 3'd1,
    CMD_PREV    = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_SHUFFLE = 3'd4,
    CMD_SHOW    = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    scan_clr;
    logic    scan_inc;
    logic    app_first;
    logic    app_link;
    logic    app_close;
    logic    step_next;
    logic    step_prev;
    logic    unlink;
    logic    clear_list;
    logic    mod_start;
    logic    steps_load;
    logic    walk_step;
    logic    report;
    status_e status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
    logic free_hit;
    logic mod_done;
    logic steps_zero;
  } dp_stat_t;

endpackage

// File: sv/clce_mod.sv
// ----------------------------------------------------------------------------
// clce_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module clce_mod import clce_pkg::*; #(
  parameter int unsigned DW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RND_W-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [DW-1:0]    rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [RND_CNT_W-1:0] cnt_q;
  logic [RND_W-1:0]     shift_q;
  logic [DW-1:0]        rem_q;
  logic [DW:0]          trial;
  logic [DW:0]          dvs;
  logic [DW:0]          diff;

  assign trial = {rem_q, shift_q[RND_W-1]};
  assign dvs   = {1'b0, divisor_i};
  assign diff  = trial - dvs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      cnt_q   <= RND_CNT_W'(RND_W - 1);
    end else if (busy_q) begin
      shift_q <= {shift_q[RND_W-2:0], 1'b0};
      cnt_q   <= cnt_q - 1'b1;
      if (trial >= dvs) begin
        rem_q <= diff[DW-1:0];
      end else begin
        rem_q <= trial[DW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/clce_dpath.sv
// ----------------------------------------------------------------------------
// clce_dpath
// List datapath: slot tables, free map, head, tail, cursor, count, results.
// ----------------------------------------------------------------------------
module clce_dpath import clce_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [RND_W-1:0]     random_value_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [ID_W-1:0]      current_entry_o,
  output logic                 current_valid_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Slot tables. All reads follow the cursor and are registered.
  logic [ID_W-1:0] ent_mem [CAPACITY];
  logic [SW-1:0]   nxt_mem [CAPACITY];
  logic [SW-1:0]   prv_mem [CAPACITY];

  logic [ID_W-1:0] ent_rd_q;
  logic [SW-1:0]   nxt_rd_q;
  logic [SW-1:0]   prv_rd_q;

  logic [SW-1:0]       head_q, head_d;
  logic [SW-1:0]       tail_q, tail_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CAPACITY-1:0] free_q, free_d;

  logic [SW-1:0]    scan_q;
  logic [CW-1:0]    steps_q;
  logic [ID_W-1:0]  id_q;
  logic [RND_W-1:0] rnd_q;

  logic          out_vld_q;
  status_e       ostat_q;
  logic          ovalid_q;
  logic [CNT_OUT_W-1:0] ocnt_q;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  logic          ent_we;
  logic          nxt_we, prv_we;
  logic [SW-1:0] nxt_wa, prv_wa;
  logic [SW-1:0] nxt_wd, prv_wd;

  logic          mod_done;
  logic [CW-1:0] mod_rem;

  clce_mod #(
    .DW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Table write ports. A new slot links between tail and head; an unlink
  // joins the neighbors of the cursor.
  always_comb begin
    ent_we = cmd_i.app_first | cmd_i.app_link;
    nxt_we = 1'b0;
    nxt_wa = scan_q;
    nxt_wd = scan_q;
    prv_we = 1'b0;
    prv_wa = scan_q;
    prv_wd = scan_q;
    if (cmd_i.app_first) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (cmd_i.app_link) begin
      nxt_we = 1'b1;
      nxt_wd = head_q;
      prv_we = 1'b1;
      prv_wd = tail_q;
    end else if (cmd_i.app_close) begin
      nxt_we = 1'b1;
      nxt_wa = tail_q;
      prv_we = 1'b1;
      prv_wa = head_q;
    end else if (cmd_i.unlink) begin
      nxt_we = 1'b1;
      nxt_wa = prv_rd_q;
      nxt_wd = nxt_rd_q;
      prv_we = 1'b1;
      prv_wa = nxt_rd_q;
      prv_wd = prv_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[scan_q] <= id_q;
    end
    ent_rd_q <= ent_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd_q <= nxt_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_rd_q <= prv_mem[cur_q];
  end

  // List state.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cur_d   = cur_q;
    count_d = count_q;
    free_d  = free_q;
    if (cmd_i.app_first || cmd_i.app_link) begin
      free_d[scan_q] = 1'b0;
      count_d        = count_q + 1'b1;
      if (cmd_i.app_first) begin
        head_d = scan_q;
        tail_d = scan_q;
        cur_d  = scan_q;
      end
    end else if (cmd_i.app_close) begin
      tail_d = scan_q;
    end else if (cmd_i.step_next || cmd_i.walk_step) begin
      cur_d = nxt_rd_q;
    end else if (cmd_i.step_prev) begin
      cur_d = prv_rd_q;
    end else if (cmd_i.unlink) begin
      free_d[cur_q] = 1'b1;
      if (head_q == cur_q) begin
        head_d = nxt_rd_q;
      end
      if (tail_q == cur_q) begin
        tail_d = prv_rd_q;
      end
      cur_d   = nxt_rd_q;
      count_d = count_q - 1'b1;
    end else if (cmd_i.clear_list) begin
      free_d[cur_q] = 1'b1;
      head_d  = '0;
      tail_d  = '0;
      cur_d   = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cur_q     <= '0;
      count_q   <= '0;
      free_q    <= '1;
      out_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      cur_q     <= cur_d;
      count_q   <= count_d;
      free_q    <= free_d;
      out_vld_q <= cmd_i.report;
    end
  end

  assign cnt_ext = (CW + CNT_OUT_W)'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q  <= entry_id_i;
      rnd_q <= random_value_i;
    end
    if (cmd_i.scan_clr) begin
      scan_q <= '0;
    end else if (cmd_i.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.steps_load) begin
      steps_q <= mod_rem;
    end else if (cmd_i.walk_step) begin
      steps_q <= steps_q - 1'b1;
    end
    if (cmd_i.report) begin
      ostat_q  <= cmd_i.status;
      ovalid_q <= (count_q != '0);
      ocnt_q   <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.single     = (count_q == CW'(1));
  assign stat_o.free_hit   = free_q[scan_q];
  assign stat_o.mod_done   = mod_done;
  assign stat_o.steps_zero = (steps_q == '0);

  assign done_o          = out_vld_q;
  assign status_o        = ostat_q;
  assign current_valid_o = ovalid_q;
  assign current_entry_o = ovalid_q ? ent_rd_q : '0;
  assign entry_count_o   = ocnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_free_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) + int'(count_q) == int'(CAPACITY))
    else $error("free map and entry count disagree");

  a_cursor_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> !free_q[cur_q])
    else $error("cursor points at a free slot");

  a_append_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.app_first || cmd_i.app_link) |-> free_q[scan_q])
    else $error("append into a slot that is in use");

endmodule

// File: sv/clce_ctrl.sv
// ----------------------------------------------------------------------------
// clce_ctrl
// Command sequencer for the circular list cursor engine.
// ----------------------------------------------------------------------------
module clce_ctrl import clce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] command_i,
  output logic             busy,
  output dp_cmd_t          cmd_o,
  input  dp_stat_t         stat_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_APPEND   = 4'd3;
  localparam logic [3:0] S_CLOSE    = 4'd4;
  localparam logic [3:0] S_MODWAIT  = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_WALKRD   = 4'd7;
  localparam logic [3:0] S_REPORT   = 4'd8;

  logic [3:0] state_q, state_d;
  cmd_e       op_q, op_d;
  status_e    status_q, status_d;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    cmd_o        = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          op_d          = cmd_e'(command_i);
          status_d      = ST_DONE;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_REPORT;
        unique case (op_q)
          CMD_APPEND: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_SCAN;
            end
          end
          CMD_NEXT: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.step_next = 1'b1;
            end
          end
          CMD_PREV: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.step_prev = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else if (stat_i.single) begin
              cmd_o.clear_list = 1'b1;
            end else begin
              cmd_o.unlink = 1'b1;
            end
          end
          CMD_SHUFFLE: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else if (!stat_i.single) begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MODWAIT;
            end
          end
          default: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.free_hit) begin
          state_d = S_APPEND;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_APPEND: begin
        if (stat_i.empty) begin
          cmd_o.app_first = 1'b1;
          state_d         = S_REPORT;
        end else begin
          cmd_o.app_link = 1'b1;
          state_d        = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd_o.app_close = 1'b1;
        state_d         = S_REPORT;
      end
      S_MODWAIT: begin
        if (stat_i.mod_done) begin
          cmd_o.steps_load = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.steps_zero) begin
          state_d = S_REPORT;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_WALKRD;
        end
      end
      S_WALKRD: begin
        state_d = S_WALK;
      end
      S_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= CMD_SHOW;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: sv/circular_list_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_core
// Bounded circular doubly linked list with a cursor, driven by commands.
//
// Next, previous, delete, show, a full append and a one-entry shuffle go
// from dispatch straight to the report; an append first scans for the lowest
// free slot; a shuffle waits for the remainder unit and then walks the links
// through the registered tables.
// Throughput: one transaction at a time; busy stays high until the strobe
// cycle. The receiver cannot stall. Reset empties the list at once.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine_core import clce_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [RND_W-1:0]     random_value_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [ID_W-1:0]      current_entry_o,
  output logic                 current_valid_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  // The controller sequences each transaction; the datapath holds the list
  // tables, the head, tail and cursor slots, the free map and the count. A
  // result is registered in the datapath and shown for one cycle on done_o.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  clce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .busy      (busy),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  // Table reads always follow the cursor slot, so each link step first updates
  // the cursor register and then waits in S_WALKRD for the registered read to settle.
  clce_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .entry_id_i      (entry_id_i),
    .random_value_i  (random_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .current_entry_o (current_entry_o),
    .current_valid_o (current_valid_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular list cursor engine. Commands go in one
// at a time through the start/busy handshake. A behavioral copy of the list
// predicts each report, and a monitor compares every done strobe with the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import clce_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY_DEF);

  // Codes 6 and 7 have no enum member. The engine treats them as show.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Cycles of quiet after the last report. The slowest command is a shuffle
  // over a full ring.
  localparam int unsigned TAIL_CYCLES = 100;

  // One expected report, field for field as the engine drives it.
  typedef struct {
    status_e                status;
    logic [ID_W-1:0]        entry;
    logic                   valid;
    logic [CNT_OUT_W-1:0]   count;
  } list_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     command_i;
  logic [ID_W-1:0]      entry_id_i;
  logic [RND_W-1:0]     random_value_i;
  logic                 done_o;
  logic [STAT_W-1:0]    status_o;
  logic [ID_W-1:0]      current_entry_o;
  logic                 current_valid_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Behavioral copy of the list: slot tables, free map, ring pointers and
  // the number of live entries.
  logic [ID_W-1:0]   id_table  [CAPACITY];
  logic [SLOT_W-1:0] fwd_link  [CAPACITY];
  logic [SLOT_W-1:0] back_link [CAPACITY];
  logic [CAPACITY-1:0] slot_open;
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr;
  logic [SLOT_W-1:0] cursor_ptr;
  int unsigned       live_count;

  list_report_t pending_reports[$];
  int unsigned  fail_count = 0;

  // When set, the command source runs back to back with no idle cycles.
  bit no_idle = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  circular_list_cursor_engine_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .entry_id_i     (entry_id_i),
    .random_value_i (random_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .current_entry_o(current_entry_o),
    .current_valid_o(current_valid_o),
    .entry_count_o  (entry_count_o)
  );

  // Apply one command to the behavioral list and return the report that the
  // engine must give for it. Slot tables are only read through live links,
  // so slots that were never written are never looked at.
  function automatic list_report_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [RND_W-1:0] rnd);
    list_report_t      rep;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] succ;
    logic [SLOT_W-1:0] pred;
    int unsigned       hops;
    bit                is_empty;
    is_empty   = (live_count == 0);
    rep.status = ST_DONE;
    slot       = '0;
    case (cmd)
      CMD_APPEND: begin
        if (live_count >= CAPACITY) begin
          rep.status = ST_FULL;
        end else begin
          // The lowest free slot takes the new entry.
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (slot_open[i]) slot = i[SLOT_W-1:0];
          end
          slot_open[slot] = 1'b0;
          id_table[slot]  = id;
          if (is_empty) begin
            // A lone entry links to itself and takes every pointer.
            fwd_link[slot]  = slot;
            back_link[slot] = slot;
            head_ptr        = slot;
            tail_ptr        = slot;
            cursor_ptr      = slot;
          end else begin
            back_link[slot]     = tail_ptr;
            fwd_link[slot]      = head_ptr;
            fwd_link[tail_ptr]  = slot;
            back_link[head_ptr] = slot;
            tail_ptr            = slot;
          end
          live_count++;
        end
      end
      CMD_NEXT: begin
        if (is_empty) rep.status = ST_EMPTY;
        else cursor_ptr = fwd_link[cursor_ptr];
      end
      CMD_PREV: begin
        if (is_empty) rep.status = ST_EMPTY;
        else cursor_ptr = back_link[cursor_ptr];
      end
      CMD_DELETE: begin
        if (is_empty) begin
          rep.status = ST_EMPTY;
        end else begin
          slot            = cursor_ptr;
          succ            = fwd_link[slot];
          pred            = back_link[slot];
          slot_open[slot] = 1'b1;
          if (live_count == 1) begin
            head_ptr   = '0;
            tail_ptr   = '0;
            cursor_ptr = '0;
            live_count = 0;
          end else begin
            // Close the ring over the hole; the cursor lands on the successor.
            fwd_link[pred]  = succ;
            back_link[succ] = pred;
            if (head_ptr == slot) head_ptr = succ;
            if (tail_ptr == slot) tail_ptr = pred;
            cursor_ptr = succ;
            live_count--;
          end
        end
      end
      CMD_SHUFFLE: begin
        if (is_empty) begin
          rep.status = ST_EMPTY;
        end else if (live_count > 1) begin
          hops = {1'b0, rnd} % live_count;
          repeat (hops) cursor_ptr = fwd_link[cursor_ptr];
        end
      end
      default: begin
        // Show, and the two spare codes that behave like it.
        if (is_empty) rep.status = ST_EMPTY;
      end
    endcase
    rep.valid = (live_count != 0);
    rep.entry = rep.valid ? id_table[cursor_ptr] : '0;
    rep.count = live_count[CNT_OUT_W-1:0];
    return rep;
  endfunction

  // Identifiers lean on the all-zero and all-one patterns now and then.
  function automatic logic [ID_W-1:0] pick_entry_id();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Shuffle amounts: zero, the maximum, small values near the ring size, and
  // full-range values so every bit is exercised.
  function automatic logic [RND_W-1:0] pick_shuffle_amount();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return RND_W'($urandom_range(40));
      default: return raw[RND_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    if (fail_count < 100) begin
      $display("%0t: check failed on %s: got %0h, expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Present one command and hold it until the engine takes it. The prediction
  // is made at the accepting edge, so pending reports stay in command order.
  // Start is always dropped after a transaction, and the next one is raised
  // no earlier than the following edge.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [RND_W-1:0] rnd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(7);
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    start          <= 1'b1;
    command_i      <= cmd;
    entry_id_i     <= id;
    random_value_i <= rnd;
    do @(posedge clk_i); while (busy);
    pending_reports.push_back(apply_list_command(cmd, id, rnd));
    start <= 1'b0;
  endtask

  // Hold the source until every outstanding report has come back.
  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Every command but append on an empty list must report an empty status.
  task automatic test_empty_list();
    send_command(CMD_NEXT, pick_entry_id(), pick_shuffle_amount());
    send_command(CMD_PREV, pick_entry_id(), pick_shuffle_amount());
    send_command(CMD_DELETE, pick_entry_id(), pick_shuffle_amount());
    send_command(CMD_SHUFFLE, pick_entry_id(), '1);
    send_command(CMD_SHOW, pick_entry_id(), pick_shuffle_amount());
    send_command(CMD_SPARE_HI, pick_entry_id(), pick_shuffle_amount());
  endtask

  // A lone entry: it becomes head, tail and cursor, a shuffle leaves the
  // cursor on it, and deleting it empties the list again.
  task automatic test_single_entry();
    send_command(CMD_APPEND, 32'hFFFF_FFFF, '0);
    send_command(CMD_SHUFFLE, '0, '1);
    send_command(CMD_DELETE, '0, '0);
  endtask

  // Fill every slot, then try one more append, which must report full.
  task automatic test_fill_to_capacity();
    logic [ID_W-1:0] id;
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       id = '0;
        1:       id = '1;
        2:       id = 32'hAAAA_AAAA;
        3:       id = 32'h5555_5555;
        default: id = $urandom();
      endcase
      send_command(CMD_APPEND, id, pick_shuffle_amount());
    end
    send_command(CMD_APPEND, 32'h1234_5678, pick_shuffle_amount());
    wait_drained();
  endtask

  // Random command mix. The append and delete shares steer the ring toward
  // full or empty so that both ends, slot reuse and head/tail deletes are hit.
  task automatic test_random_traffic(input int items, input int append_pct,
                                     input int delete_pct);
    int              roll;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < items; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
      roll = $urandom_range(99);
      if (roll < append_pct) begin
        cmd = CMD_APPEND;
      end else if (roll < append_pct + delete_pct) begin
        cmd = CMD_DELETE;
      end else begin
        case ($urandom_range(9))
          0, 1, 2: cmd = CMD_NEXT;
          3, 4:    cmd = CMD_PREV;
          5, 6, 7: cmd = CMD_SHUFFLE;
          8:       cmd = CMD_SHOW;
          default: cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        endcase
      end
      send_command(cmd, pick_entry_id(), pick_shuffle_amount());
    end
    no_idle = 1'b0;
  endtask

  // Monitor: the engine cannot be stalled, so each strobe cycle is one report
  // and is compared against the oldest prediction.
  always @(posedge clk_i) begin
    list_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report", current_entry_o, '0);
      end else begin
        want = pending_reports.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", ID_W'(status_o), ID_W'(want.status));
        end
        if (current_entry_o !== want.entry) begin
          report_mismatch("current_entry", current_entry_o, want.entry);
        end
        if (current_valid_o !== want.valid) begin
          report_mismatch("current_valid", ID_W'(current_valid_o), ID_W'(want.valid));
        end
        if (entry_count_o !== want.count) begin
          report_mismatch("entry_count", ID_W'(entry_count_o), ID_W'(want.count));
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    command_i      <= CMD_SHOW;
    entry_id_i     <= '0;
    random_value_i <= '0;
    // The behavioral list starts empty, like the engine after reset.
    for (int i = 0; i < CAPACITY; i++) begin
      id_table[i]  = '0;
      fwd_link[i]  = '0;
      back_link[i] = '0;
    end
    slot_open  = '1;
    head_ptr   = '0;
    tail_ptr   = '0;
    cursor_ptr = '0;
    live_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_single_entry();
    test_fill_to_capacity();
    // Start full, drain hard, refill, then settle into an even mix.
    test_random_traffic(375, 30, 30);
    wait_drained();
    test_random_traffic(375, 10, 50);
    wait_drained();
    test_random_traffic(375, 55, 10);
    test_random_traffic(375, 30, 25);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("circular_list_cursor_engine_core: match");
    end else begin
      $display("circular_list_cursor_engine_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this command count.
  initial begin
    #20_000_000;
    $display("circular_list_cursor_engine_core: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
sv/clce_pkg.sv
sv/clce_mod.sv
sv/clce_dpath.sv
sv/clce_ctrl.sv
sv/circular_list_cursor_engine_core.sv
test/tb_top.sv
